// ===== design/lbffi_pkg.sv =====
// Package for the link bit-flip fault injector.
// Fault-record field widths, the record type and register addresses; no dependencies.
package lbffi_pkg;

    localparam int WIRE_W  = 5;   // fault_wire
    localparam int WCNT_W  = 6;   // wire_count
    localparam int DUR_W   = 9;   // fault_duration
    localparam int FAULT_W = 1 + WIRE_W + WCNT_W + DUR_W;

    // word index of the inject_enable register (paddr[2])
    localparam logic REG_INJECT_EN = 1'b0;

    // declared high field first: fault_valid lands in the lowest bit, as on tdata
    typedef struct packed {
        logic [DUR_W-1:0]  fault_duration;
        logic [WCNT_W-1:0] wire_count;
        logic [WIRE_W-1:0] fault_wire;
        logic              fault_valid;
    } t_fault;

endpackage

// ===== design/lbffi_window.sv =====
// Fault window decode: bit mask of the wires one fault flips and its counter load.
// Uses lbffi_pkg::t_fault.
module lbffi_window #(
    parameter int DATA_BITS  = 32,
    parameter int COUNT_BITS = 8
) (
    input  lbffi_pkg::t_fault      i_fault,
    output logic [DATA_BITS-1:0]   o_mask,
    output logic [COUNT_BITS-1:0]  o_load
);

    localparam int IW = ($clog2(DATA_BITS) + 2 > 7) ? $clog2(DATA_BITS) + 2 : 7;
    localparam int LW = (COUNT_BITS > lbffi_pkg::DUR_W) ? COUNT_BITS : lbffi_pkg::DUR_W;

    logic [IW-1:0]                 wire_x;
    logic [IW-1:0]                 cnt_x;
    logic [IW-1:0]                 cnt_sat;
    logic [IW-1:0]                 half;
    logic [IW-1:0]                 start;
    logic [DATA_BITS:0]            low;
    logic [lbffi_pkg::DUR_W-1:0]   dur_m1;
    logic [LW-1:0]                 load_w;
    logic [LW-1:0]                 load_max;

    always_comb begin
        wire_x  = IW'(i_fault.fault_wire);
        cnt_x   = IW'(i_fault.wire_count);
        cnt_sat = (cnt_x > IW'(DATA_BITS)) ? IW'(DATA_BITS) : cnt_x;
        half    = cnt_sat >> 1;
        start   = (wire_x > half) ? wire_x - half : '0;
        // keep the window inside the vector: slide it down to end at the top bit
        if (start + cnt_sat > IW'(DATA_BITS)) begin
            start = IW'(DATA_BITS) - cnt_sat;
        end
        low = ~({(DATA_BITS + 1){1'b1}} << cnt_sat);
        o_mask = i_fault.fault_valid ? (low[DATA_BITS-1:0] << start) : '0;

        dur_m1   = (i_fault.fault_duration == '0) ? '0 : i_fault.fault_duration - 1'b1;
        load_w   = LW'(dur_m1);
        load_max = LW'({COUNT_BITS{1'b1}});
        o_load   = (load_w > load_max) ? load_max[COUNT_BITS-1:0] : load_w[COUNT_BITS-1:0];
    end

endmodule

// ===== design/link_bit_flip_fault_injector_top.sv =====
// Top level of the link bit-flip fault injector: stream ports, APB register, state.
// Depends on lbffi_pkg and lbffi_window.

// One beat per cycle in and out while the output is not held. The result of a tlast beat
// passes through an input register, then one pass of window decode and counter update
// into the output register. All DATA_BITS persistence counters update in parallel in
// that pass. A flit is any number of fault beats; only the tlast beat yields a result,
// carrying that beat's error vector with this flit's toggles and the still-persisting
// flips of earlier faults applied. The input stalls only while a tlast beat waits in
// the input register behind a held result. With inject_enable clear the vector passes
// unchanged and the counters hold. No clearing pass after reset.
module link_bit_flip_fault_injector_top #(
    parameter int DATA_BITS  = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // APB register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // low to high: error_vector, fault_valid, fault_wire, wire_count, fault_duration
    input  logic [((DATA_BITS + lbffi_pkg::FAULT_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,   // last_fault
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // low to high: faulty_vector
    output logic [((DATA_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int ODW = ((DATA_BITS + 7) / 8) * 8;

    logic                  r_en;
    logic                  r_s1_valid;
    logic                  r_s1_last;
    logic [DATA_BITS-1:0]  r_s1_vec;
    lbffi_pkg::t_fault     r_s1_fault;
    logic                  r_out_valid;
    logic [DATA_BITS-1:0]  r_out_vec;
    logic [DATA_BITS-1:0]  r_pend_toggle;
    logic [DATA_BITS-1:0]  r_pend_hit;
    logic [COUNT_BITS-1:0] r_cnt [DATA_BITS];

    logic [DATA_BITS-1:0]  n_pend_toggle;
    logic [DATA_BITS-1:0]  n_pend_hit;
    logic [COUNT_BITS-1:0] n_cnt [DATA_BITS];
    logic [DATA_BITS-1:0]  n_out_vec;

    logic                  s1_go;
    logic                  cfg_wr;
    logic [DATA_BITS-1:0]  win_mask;
    logic [COUNT_BITS-1:0] win_load;
    logic [DATA_BITS-1:0]  hit_mask;
    logic [DATA_BITS-1:0]  tog_all;
    logic [DATA_BITS-1:0]  hit_all;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (cfg_wr && paddr[2] == lbffi_pkg::REG_INJECT_EN) begin
            r_en <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == lbffi_pkg::REG_INJECT_EN) ? {31'b0, r_en} : 32'b0;

    // ---------------- input register ----------------
    // non-last beats never need the output slot
    assign s1_go = r_s1_valid && (!r_s1_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_vec   <= s_axis_tdata[DATA_BITS-1:0];
            r_s1_fault <= s_axis_tdata[DATA_BITS + lbffi_pkg::FAULT_W - 1:DATA_BITS];
            r_s1_last  <= s_axis_tlast;
        end
    end

    // ---------------- fault update pass ----------------
    lbffi_window #(
        .DATA_BITS  (DATA_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_window (
        .i_fault (r_s1_fault),
        .o_mask  (win_mask),
        .o_load  (win_load)
    );

    always_comb begin
        hit_mask = r_en ? win_mask : '0;
        tog_all  = r_pend_toggle ^ hit_mask;
        hit_all  = r_pend_hit | hit_mask;
        n_out_vec = r_s1_vec;
        if (r_en) begin
            n_out_vec = r_s1_vec ^ tog_all;
        end
        for (int i = 0; i < DATA_BITS; i++) begin
            n_cnt[i] = hit_mask[i] ? win_load : r_cnt[i];
            // bits not hit this flit keep flipping while their counter runs
            if (r_s1_last && r_en && !hit_all[i] && n_cnt[i] != '0) begin
                n_out_vec[i] = ~n_out_vec[i];
                n_cnt[i]     = n_cnt[i] - 1'b1;
            end
        end
        if (r_s1_last) begin
            n_pend_toggle = '0;
            n_pend_hit    = '0;
        end else begin
            n_pend_toggle = tog_all;
            n_pend_hit    = hit_all;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_toggle <= '0;
            r_pend_hit    <= '0;
            for (int i = 0; i < DATA_BITS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (s1_go) begin
            r_pend_toggle <= n_pend_toggle;
            r_pend_hit    <= n_pend_hit;
            for (int i = 0; i < DATA_BITS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_vec <= n_out_vec;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ODW'(r_out_vec);

    // ---------------- assertions ----------------
    a_toggle_in_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_toggle & ~r_pend_hit) == '0)
        else $error("pending toggle outside pending hit mask");

    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_last) |=> (r_pend_toggle == '0 && r_pend_hit == '0))
        else $error("pending masks not cleared after last beat");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_go && r_s1_last))
        else $error("result beat without a processed last beat");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_valid && r_s1_last && r_out_valid))
        else $error("input stalled without a blocked last beat");

endmodule
